FILE: rtl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types and constants for the quaternion to Euler angle pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

  // Width of the CORDIC vector datapath, wide enough for the 2^32 operands
  // times the CORDIC gain.
  localparam int CW = 40;

  // Square root chain: one result bit per cell, radicand below 2^61.
  localparam int SQRT_STEPS = 31;
  localparam int SQRT_TOP   = 60;
  localparam int SQW        = 62;

  localparam logic [31:0] HALF_PI_ACC = 32'h4000_0000;

  // Tag bits carried down a CORDIC chain.
  localparam int TAG_ZERO = 0;  // result is forced to zero
  localparam int TAG_POLE = 1;  // pitch sits exactly at the pole
  localparam int TAG_NEG  = 2;  // pitch is negated at the end

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef logic signed [CW-1:0] cvec_t;

  typedef struct packed {
    cvec_t       x;
    cvec_t       y;
    logic [31:0] z;
    logic [2:0]  tag;
  } cordic_t;

  typedef struct packed {
    logic [SQW-1:0] v;
    logic [SQW-1:0] res;
  } sqrt_t;

endpackage

FILE: rtl/qte_quat_if.sv
// ----------------------------------------------------------------------------
// qte_quat_if
// Valid/ready channel carrying one quaternion item.
// ----------------------------------------------------------------------------
interface qte_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

FILE: rtl/qte_euler_if.sv
// ----------------------------------------------------------------------------
// qte_euler_if
// Valid/ready channel carrying one set of Euler angles.
// ----------------------------------------------------------------------------
interface qte_euler_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

FILE: rtl/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Converts a fixed-point quaternion to XYZ Euler angles in binary angle form.
// ----------------------------------------------------------------------------
//
//   channel  | role   | payload                                 | handshake
//   ---------+--------+-----------------------------------------+-----------
//   quat     | sink   | quat_w, quat_x, quat_y, quat_z (s16)     | valid/ready
//   euler    | source | roll_angle, pitch_angle, yaw_angle (s16) | valid/ready
//
// One item is taken every cycle unless the output stalls. Each item passes
// through four front stages, thirty-one square root cells, one quadrant
// fold, the CORDIC cells and the output register. Reset clears the valid
// bits and the side delay lines; the datapath registers keep whatever they
// hold, so no clearing pass is needed. The whole pipeline advances as one;
// it holds when a result waits at the output and the sink is not ready,
// and otherwise keeps moving.
//
// The quaternion is never normalized. All terms are scaled by the squared
// norm n, so roll and yaw are plain atan2 values, and pitch is taken as
// atan2(|s|, sqrt((n-|s|)(n+|s|))) with |s| clamped to n. An all-zero
// quaternion falls out as zero angles on its own.
//
module quaternion_to_euler_angles #(
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic     clk,
  input  logic     rst,
  qte_quat_if.sink    quat,
  qte_euler_if.source euler
);

  localparam int          RSH = 32 - ANGLE_BITS;
  localparam logic [31:0] RND = (32'd1 << RSH) >> 1;
  localparam int          FW  = 35;  // front datapath width

  // The pipeline advances whenever the output register can take an item.
  logic adv;
  assign adv        = !euler.valid || euler.ready;
  assign quat.ready = adv;

  // Stage 1: the ten products.
  logic               v1, v2, v3, v4;
  logic signed [31:0] p_ww, p_xx, p_yy, p_zz, p_wx, p_yz, p_wz, p_xy, p_wy, p_zx;

  // Stage 2: norm and the three vectors.
  logic signed [FW-1:0] n2, ry2, rx2, yy2, yx2, s2;
  logic signed [FW-1:0] n_c;

  // Stage 3: clamped and scaled pitch operands.
  logic signed [FW-1:0] m_abs, m_cl, nn_c, mm_c;
  logic [30:0]          a3, m3;
  logic [31:0]          b3;
  logic                 neg3;

  // Stage 4: cosine term squared.
  logic [62:0] prod_c;
  logic [60:0] c2_4;
  logic [30:0] m4;
  logic        neg4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= quat.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  assign n_c = FW'(p_ww) + FW'(p_xx) + FW'(p_yy) + FW'(p_zz);

  always_comb begin
    m_abs = (s2 < 0) ? -s2 : s2;
    m_cl  = (m_abs > n2) ? n2 : m_abs;
    // A large norm is scaled down so the product below stays within 61 bits.
    if (n2 >= (FW'(1) <<< 30)) begin
      nn_c = n2 >>> 2;
      mm_c = m_cl >>> 2;
    end else begin
      nn_c = n2;
      mm_c = m_cl;
    end
  end

  assign prod_c = {32'd0, a3} * {31'd0, b3};

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ww <= quat.quat_w * quat.quat_w;
      p_xx <= quat.quat_x * quat.quat_x;
      p_yy <= quat.quat_y * quat.quat_y;
      p_zz <= quat.quat_z * quat.quat_z;
      p_wx <= quat.quat_w * quat.quat_x;
      p_yz <= quat.quat_y * quat.quat_z;
      p_wz <= quat.quat_w * quat.quat_z;
      p_xy <= quat.quat_x * quat.quat_y;
      p_wy <= quat.quat_w * quat.quat_y;
      p_zx <= quat.quat_z * quat.quat_x;

      n2  <= n_c;
      ry2 <= (FW'(p_wx) + FW'(p_yz)) <<< 1;
      rx2 <= n_c - ((FW'(p_xx) + FW'(p_yy)) <<< 1);
      yy2 <= (FW'(p_wz) + FW'(p_xy)) <<< 1;
      yx2 <= n_c - ((FW'(p_yy) + FW'(p_zz)) <<< 1);
      s2  <= (FW'(p_wy) - FW'(p_zx)) <<< 1;

      a3   <= 31'(nn_c - mm_c);
      b3   <= 32'(nn_c + mm_c);
      m3   <= 31'(mm_c);
      neg3 <= (s2 < 0);

      c2_4 <= prod_c[60:0];
      m4   <= m3;
      neg4 <= neg3;
    end
  end

  // Square root chain: one result bit per cell.
  qte_pkg::sqrt_t sq [qte_pkg::SQRT_STEPS + 1];
  assign sq[0] = '{v: qte_pkg::SQW'(c2_4), res: '0};

  for (genvar k = 0; k < qte_pkg::SQRT_STEPS; k++) begin : g_sqrt
    qte_sqrt_cell #(.SHIFT(qte_pkg::SQRT_TOP - 2 * k)) u_cell (
      .clk (clk),
      .en  (adv),
      .d   (sq[k]),
      .q   (sq[k+1])
    );
  end

  // Pitch side data rides beside the square root chain.
  logic [30:0] m_d;
  logic        neg_d, pole_d, v35;
  logic [30:0] root;

  qte_delay #(.W(33), .D(qte_pkg::SQRT_STEPS)) u_pitch_side (
    .clk (clk),
    .rst (rst),
    .en  (adv),
    .d   ({m4, neg4, (c2_4 == '0)}),
    .q   ({m_d, neg_d, pole_d})
  );

  qte_delay #(.W(1), .D(qte_pkg::SQRT_STEPS)) u_valid_a (
    .clk (clk),
    .rst (rst),
    .en  (adv),
    .d   (v4),
    .q   (v35)
  );

  assign root = sq[qte_pkg::SQRT_STEPS].res[30:0];

  // Roll and yaw vectors wait for the pitch operands.
  logic signed [FW-1:0] ry_d, rx_d, yy_d, yx_d;

  qte_delay #(.W(4 * FW), .D(qte_pkg::SQRT_STEPS + 2)) u_ry_side (
    .clk (clk),
    .rst (rst),
    .en  (adv),
    .d   ({ry2, rx2, yy2, yx2}),
    .q   ({ry_d, rx_d, yy_d, yx_d})
  );

  // Three CORDIC chains run side by side.
  qte_pkg::cordic_t cr_roll  [CORDIC_STAGES + 1];
  qte_pkg::cordic_t cr_pitch [CORDIC_STAGES + 1];
  qte_pkg::cordic_t cr_yaw   [CORDIC_STAGES + 1];

  qte_cordic_pre u_pre_roll (
    .clk (clk),
    .en  (adv),
    .x   (qte_pkg::CW'(rx_d)),
    .y   (qte_pkg::CW'(ry_d)),
    .tag (3'b000),
    .q   (cr_roll[0])
  );

  qte_cordic_pre u_pre_yaw (
    .clk (clk),
    .en  (adv),
    .x   (qte_pkg::CW'(yx_d)),
    .y   (qte_pkg::CW'(yy_d)),
    .tag (3'b000),
    .q   (cr_yaw[0])
  );

  // A zero sine gives zero pitch, so it shares the zero tag.
  qte_cordic_pre u_pre_pitch (
    .clk (clk),
    .en  (adv),
    .x   (qte_pkg::cvec_t'({1'b0, root})),
    .y   (qte_pkg::cvec_t'({1'b0, m_d})),
    .tag ({neg_d, pole_d, (m_d == '0)}),
    .q   (cr_pitch[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    qte_cordic_cell #(.STAGE(i)) u_roll (
      .clk (clk), .en (adv), .d (cr_roll[i]), .q (cr_roll[i+1])
    );
    qte_cordic_cell #(.STAGE(i)) u_pitch (
      .clk (clk), .en (adv), .d (cr_pitch[i]), .q (cr_pitch[i+1])
    );
    qte_cordic_cell #(.STAGE(i)) u_yaw (
      .clk (clk), .en (adv), .d (cr_yaw[i]), .q (cr_yaw[i+1])
    );
  end

  logic vend;

  qte_delay #(.W(1), .D(CORDIC_STAGES + 1)) u_valid_b (
    .clk (clk),
    .rst (rst),
    .en  (adv),
    .d   (v35),
    .q   (vend)
  );

  // Final angle selection and rounding to the output angle width.
  qte_pkg::cordic_t rl, pt, yw;
  logic [31:0]      roll_acc, pitch_base, pitch_acc, yaw_acc;

  assign rl = cr_roll[CORDIC_STAGES];
  assign pt = cr_pitch[CORDIC_STAGES];
  assign yw = cr_yaw[CORDIC_STAGES];

  function automatic logic [15:0] round_angle(input logic [31:0] acc);
    logic [31:0] r;
    r = (acc + RND) >> RSH;
    return r[15:0];
  endfunction

  always_comb begin
    roll_acc = rl.tag[qte_pkg::TAG_ZERO] ? 32'd0 : rl.z;
    yaw_acc  = yw.tag[qte_pkg::TAG_ZERO] ? 32'd0 : yw.z;
    if (pt.tag[qte_pkg::TAG_ZERO]) begin
      pitch_base = 32'd0;
    end else if (pt.tag[qte_pkg::TAG_POLE]) begin
      pitch_base = qte_pkg::HALF_PI_ACC;
    end else if (pt.z > qte_pkg::HALF_PI_ACC) begin
      pitch_base = qte_pkg::HALF_PI_ACC;
    end else begin
      pitch_base = pt.z;
    end
    pitch_acc = pt.tag[qte_pkg::TAG_NEG] ? (32'd0 - pitch_base) : pitch_base;
  end

  logic               out_valid;
  logic signed [15:0] roll_q, pitch_q, yaw_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vend;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      roll_q  <= round_angle(roll_acc);
      pitch_q <= round_angle(pitch_acc);
      yaw_q   <= round_angle(yaw_acc);
    end
  end

  assign euler.valid       = out_valid;
  assign euler.roll_angle  = roll_q;
  assign euler.pitch_angle = pitch_q;
  assign euler.yaw_angle   = yaw_q;

  // A stalled pipeline keeps its items in place.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v1) && $stable(v4) && $stable(v35))
    else $error("pipeline valid bits moved during a stall");

  // An accepted item shows up in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    quat.valid && quat.ready |=> v1)
    else $error("accepted item missing from first stage");

  // A nonzero cosine product always has a nonzero root.
  a_root_nonzero: assert property (@(posedge clk) disable iff (rst)
    v35 && !pole_d |-> root != '0)
    else $error("square root is zero for a nonzero radicand");

  // Pitch never leaves the half circle.
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    vend |-> ($signed(pitch_acc) <= $signed(qte_pkg::HALF_PI_ACC)) &&
             ($signed(pitch_acc) >= -$signed(qte_pkg::HALF_PI_ACC)))
    else $error("pitch outside plus or minus half pi");

endmodule

FILE: rtl/qte_delay.sv
// ----------------------------------------------------------------------------
// qte_delay
// Enabled shift line that carries side data alongside the datapath.
// ----------------------------------------------------------------------------
module qte_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] taps [D];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < D; i++) taps[i] <= '0;
    end else if (en) begin
      taps[0] <= d;
      for (int i = 1; i < D; i++) taps[i] <= taps[i-1];
    end
  end

  assign q = taps[D-1];

endmodule

FILE: rtl/qte_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// One digit of a restoring integer square root, registered.
// ----------------------------------------------------------------------------
module qte_sqrt_cell #(
  parameter int SHIFT = 0
) (
  input  logic            clk,
  input  logic            en,
  input  qte_pkg::sqrt_t  d,
  output qte_pkg::sqrt_t  q
);

  localparam logic [qte_pkg::SQW-1:0] BIT = qte_pkg::SQW'(1) << SHIFT;

  logic [qte_pkg::SQW-1:0] trial;
  qte_pkg::sqrt_t          nx;

  always_comb begin
    trial = d.res + BIT;
    if (d.v >= trial) begin
      nx.v   = d.v - trial;
      nx.res = (d.res >> 1) + BIT;
    end else begin
      nx.v   = d.v;
      nx.res = d.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= nx;
  end

endmodule

FILE: rtl/qte_cordic_pre.sv
// ----------------------------------------------------------------------------
// qte_cordic_pre
// Quadrant fold ahead of a CORDIC chain; flags the zero vector.
// ----------------------------------------------------------------------------
module qte_cordic_pre (
  input  logic             clk,
  input  logic             en,
  input  qte_pkg::cvec_t   x,
  input  qte_pkg::cvec_t   y,
  input  logic [2:0]       tag,
  output qte_pkg::cordic_t q
);

  qte_pkg::cordic_t nx;

  always_comb begin
    nx.x   = x;
    nx.y   = y;
    nx.z   = '0;
    nx.tag = tag;
    if (x == '0 && y == '0) nx.tag[qte_pkg::TAG_ZERO] = 1'b1;
    if (x < 0) begin
      if (y >= 0) begin
        nx.x = y;
        nx.y = -x;
        nx.z = qte_pkg::HALF_PI_ACC;
      end else begin
        nx.x = -y;
        nx.y = x;
        nx.z = 32'd0 - qte_pkg::HALF_PI_ACC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= nx;
  end

endmodule

FILE: rtl/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell
// One vectoring CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module qte_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             en,
  input  qte_pkg::cordic_t d,
  output qte_pkg::cordic_t q
);

  localparam logic [31:0] ANGLE = qte_pkg::ATAN_TAB[STAGE];

  qte_pkg::cvec_t   dx;
  qte_pkg::cvec_t   dy;
  qte_pkg::cordic_t nx;

  always_comb begin
    dx     = d.y >>> STAGE;
    dy     = d.x >>> STAGE;
    nx.tag = d.tag;
    if (d.y >= 0) begin
      nx.x = d.x + dx;
      nx.y = d.y - dy;
      nx.z = d.z + ANGLE;
    end else begin
      nx.x = d.x - dx;
      nx.y = d.y + dy;
      nx.z = d.z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= nx;
  end

endmodule

FILE: verif/tb_quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_angles
// Self-checking testbench for the quaternion to Euler angle pipeline.
// ----------------------------------------------------------------------------
//
// Quaternions are sent on the quat channel. A predictor in this file works out
// the expected roll, pitch and yaw for each accepted item, using the same
// norm-scaled atan2 formulation and a bit-exact CORDIC. Angle sets leaving on
// the euler channel are compared field by field with the oldest prediction.
// Both channels idle at random in several phases. One phase holds the sink off
// for a long stretch so that the pipeline fills and stalls its input.
//
module tb_quaternion_to_euler_angles;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES  = 16;
  localparam int ABITS   = 16;
  localparam int LATENCY = 37 + STAGES;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } angles_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #1 clk = ~clk;

  qte_quat_if  quat_ch ();
  qte_euler_if euler_ch ();

  quaternion_to_euler_angles #(
    .ANGLE_BITS(ABITS),
    .CORDIC_STAGES(STAGES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .quat(quat_ch.sink),
    .euler(euler_ch.source)
  );

  // Predicted angle sets, oldest first.
  angles_t pending_angles[$];
  int      error_count = 0;

  // Idling controls, in percent. The hold-off count stalls the sink outright.
  int unsigned send_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned holdoff_cycles = 0;

  // -------------------------------------------------------------------------
  // Predictor.
  // -------------------------------------------------------------------------

  // Floor shift right: an arithmetic shift on a signed value is exactly this.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // Vectoring CORDIC atan2 with a 32-bit angle, 2^31 standing for pi.
  function automatic logic [31:0] vector_angle(longint y, longint x);
    logic [31:0] acc;
    longint t;
    longint dx;
    longint dy;
    acc = 32'd0;
    if (x == 0 && y == 0) return 32'd0;
    // Fold the left half plane onto the right by a quarter turn.
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        acc = qte_pkg::HALF_PI_ACC;
      end else begin
        x = -y;
        y = t;
        acc = 32'd0 - qte_pkg::HALF_PI_ACC;
      end
    end
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y >= 0) begin
        x += dx;
        y -= dy;
        acc += qte_pkg::ATAN_TAB[i];
      end else begin
        x -= dx;
        y += dy;
        acc -= qte_pkg::ATAN_TAB[i];
      end
    end
    return acc;
  endfunction

  // Bitwise integer square root.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Round the 32-bit accumulator to the output angle width.
  function automatic logic signed [15:0] round_angle(logic [31:0] acc);
    logic [31:0] r;
    r = acc;
    if (ABITS < 32) begin
      r += 32'd1 << (31 - ABITS);
      r >>= (32 - ABITS);
    end
    return r[15:0];
  endfunction

  function automatic angles_t euler_from_quat(logic signed [15:0] qw, logic signed [15:0] qx,
                                              logic signed [15:0] qy, logic signed [15:0] qz);
    longint w, x, y, z, n, s, m, nn, c2;
    logic [31:0] roll_acc, pitch_acc, yaw_acc;
    angles_t res;
    w = longint'(qw);
    x = longint'(qx);
    y = longint'(qy);
    z = longint'(qz);
    n = w * w + x * x + y * y + z * z;
    if (n == 0) return '0;
    roll_acc = vector_angle(2 * (w * x + y * z), n - 2 * (x * x + y * y));
    yaw_acc  = vector_angle(2 * (w * z + x * y), n - 2 * (y * y + z * z));
    // Pitch works on the magnitude of the sine term, clamped to the norm.
    s = 2 * (w * y - z * x);
    m = (s < 0) ? -s : s;
    if (m > n) m = n;
    nn = n;
    if (nn >= (64'sd1 << 30)) begin
      nn >>= 2;
      m >>= 2;
    end
    c2 = (nn - m) * (nn + m);
    if (m == 0) begin
      pitch_acc = 32'd0;
    end else if (c2 == 0) begin
      pitch_acc = qte_pkg::HALF_PI_ACC;
    end else begin
      pitch_acc = vector_angle(m, longint'(int_sqrt(longint'(c2))));
      if (pitch_acc > qte_pkg::HALF_PI_ACC) pitch_acc = qte_pkg::HALF_PI_ACC;
    end
    if (s < 0) pitch_acc = 32'd0 - pitch_acc;
    res.roll  = round_angle(roll_acc);
    res.pitch = round_angle(pitch_acc);
    res.yaw   = round_angle(yaw_acc);
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // Sending side. Inputs change on the falling edge only.
  // -------------------------------------------------------------------------

  initial begin
    quat_ch.valid  = 1'b0;
    quat_ch.quat_w = '0;
    quat_ch.quat_x = '0;
    quat_ch.quat_y = '0;
    quat_ch.quat_z = '0;
    euler_ch.ready = 1'b0;
  end

  // Offers one quaternion and returns after it has been accepted. Valid is
  // left high; the next call or the idle gap decides whether it drops.
  task automatic send_quat(logic signed [15:0] qw, logic signed [15:0] qx,
                           logic signed [15:0] qy, logic signed [15:0] qz);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      quat_ch.valid <= 1'b0;
      @(negedge clk);
    end
    quat_ch.valid  <= 1'b1;
    quat_ch.quat_w <= qw;
    quat_ch.quat_x <= qx;
    quat_ch.quat_y <= qy;
    quat_ch.quat_z <= qz;
    do @(posedge clk); while (!quat_ch.ready);
    pending_angles.insert(pending_angles.size(), euler_from_quat(qw, qx, qy, qz));
    @(negedge clk);
  endtask

  // Drops valid and waits on the falling clock edge, so the next offer never lands
  // in the same time step.
  task automatic release_quat();
    quat_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Sink ready, redrawn every falling edge while no hold-off is running.
  always @(negedge clk) begin
    if (rst) begin
      euler_ch.ready <= 1'b0;
    end else if (holdoff_cycles != 0) begin
      euler_ch.ready <= 1'b0;
      holdoff_cycles <= holdoff_cycles - 1;
    end else begin
      euler_ch.ready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Checking side.
  // -------------------------------------------------------------------------

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    angles_t want;
    if (!rst && euler_ch.valid && euler_ch.ready) begin
      if (pending_angles.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = pending_angles.pop_front();
        if (euler_ch.roll_angle !== want.roll)
          report_mismatch("roll", int'(euler_ch.roll_angle), int'(want.roll));
        if (euler_ch.pitch_angle !== want.pitch)
          report_mismatch("pitch", int'(euler_ch.pitch_angle), int'(want.pitch));
        if (euler_ch.yaw_angle !== want.yaw)
          report_mismatch("yaw", int'(euler_ch.yaw_angle), int'(want.yaw));
      end
    end
  end

  // -------------------------------------------------------------------------
  // Tests.
  // -------------------------------------------------------------------------

  function automatic logic signed [15:0] rand_comp();
    return 16'($urandom);
  endfunction

  // Extremes of each component, the zero quaternion, poles and the wrap at pi.
  task automatic test_directed();
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_quat(-16'sd32768, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    // Pitch exactly at the poles, small and large norm.
    send_quat(16'sd1000, 16'sd0, 16'sd1000, 16'sd0);
    send_quat(16'sd1000, 16'sd0, -16'sd1000, 16'sd0);
    send_quat(16'sd32767, 16'sd0, 16'sd32767, 16'sd0);
    send_quat(-16'sd32768, 16'sd0, -16'sd32768, 16'sd0);
    send_quat(16'sd5, 16'sd5, 16'sd5, -16'sd5);
    // Half turns: roll and yaw land on pi and wrap to the negative code.
    send_quat(16'sd0, 16'sd20000, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd20000);
    send_quat(16'sd0, 16'sd0, 16'sd20000, 16'sd0);
    send_quat(16'sd0, -16'sd32768, 16'sd0, 16'sd0);
    // Single-component extremes and the smallest nonzero inputs.
    send_quat(16'sd0, 16'sd32767, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, -16'sd32768, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd32767);
    send_quat(16'sd1, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, -16'sd1, 16'sd0, 16'sd0);
    send_quat(16'sd1, 16'sd1, -16'sd1, 16'sd1);
    send_quat(16'sd32767, -16'sd1, 16'sd1, -16'sd32768);
    release_quat();
  endtask

  // Random quaternions at mixed scales, so both norm ranges are well covered.
  task automatic test_random(int count);
    int sh;
    for (int i = 0; i < count; i++) begin
      sh = $urandom_range(15);
      send_quat(rand_comp() >>> sh, rand_comp() >>> sh, rand_comp() >>> sh,
                rand_comp() >>> sh);
    end
    release_quat();
  endtask

  // The sink holds off long enough for the whole pipeline to fill while the
  // sender keeps offering items, so the input must stall and then resume.
  task automatic test_backpressure();
    holdoff_cycles = 4 * LATENCY;
    test_random(3 * LATENCY);
  endtask

  task automatic drain();
    while (pending_angles.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random(450);
    drain();

    send_idle_pct = 58;
    test_random(400);
    drain();

    send_idle_pct  = 0;
    sink_stall_pct = 58;
    test_random(400);
    drain();

    send_idle_pct  = 11;
    sink_stall_pct = 11;
    test_random(400);
    drain();

    sink_stall_pct = 0;
    send_idle_pct  = 0;
    test_backpressure();
    drain();

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

endmodule
